### design/tlpa_pkg.sv
// Shared widths, register indexes, mode codes and payload types of the tile layer address unit.
package tlpa_pkg;

  localparam int SIZE_W        = 13;
  localparam int POS_W         = 16;
  localparam int PIX_W         = 12;
  localparam int CFG_W         = 14;
  localparam int IDX_W         = 3;
  localparam int OFS_W         = 14;
  localparam int DIV_W         = 14;
  localparam int REM_W         = 13;
  localparam int ALPHA_W       = 8;
  localparam int LANES         = 4;
  localparam int MAX_SIZE      = 4096;
  localparam int FEATHER_WIDTH = 4;
  localparam int ALPHA_FULL    = 255;

  localparam logic [IDX_W-1:0] REG_CANVAS_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_CANVAS_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_TILE_WIDTH    = 3'd2;
  localparam logic [IDX_W-1:0] REG_TILE_HEIGHT   = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFFSET_X      = 3'd4;
  localparam logic [IDX_W-1:0] REG_OFFSET_Y      = 3'd5;
  localparam logic [IDX_W-1:0] REG_ANCHOR_MODE   = 3'd6;
  localparam logic [IDX_W-1:0] REG_LAYOUT_MODE   = 3'd7;

  localparam logic [2:0] ANCHOR_TOP_LEFT     = 3'd1;
  localparam logic [2:0] ANCHOR_TOP_RIGHT    = 3'd2;
  localparam logic [2:0] ANCHOR_BOTTOM_LEFT  = 3'd3;
  localparam logic [2:0] ANCHOR_BOTTOM_RIGHT = 3'd4;

  localparam logic [1:0] LAYOUT_SINGLE = 2'd0;
  localparam logic [1:0] LAYOUT_CLAMP  = 2'd1;
  localparam logic [1:0] LAYOUT_REPEAT = 2'd2;
  localparam logic [1:0] LAYOUT_MIRROR = 2'd3;

  localparam logic [1:0] DIR_X_ONLY = 2'd1;
  localparam logic [1:0] DIR_Y_ONLY = 2'd2;

  // Divider lanes: position and anchor numerators for each axis.
  localparam int LANE_X_POS = 0;
  localparam int LANE_X_ANC = 1;
  localparam int LANE_Y_POS = 2;
  localparam int LANE_Y_ANC = 3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic               covered;
    logic [PIX_W-1:0]   source_x;
    logic [PIX_W-1:0]   source_y;
    logic [ALPHA_W-1:0] edge_alpha;
  } out_t;

  typedef struct packed {
    logic [SIZE_W-1:0]       cw;
    logic [SIZE_W-1:0]       ch;
    logic [SIZE_W-1:0]       tw;
    logic [SIZE_W-1:0]       th;
    logic signed [POS_W-1:0] ax;
    logic signed [POS_W-1:0] ay;
    logic                    clamp;
    logic                    tiled;
    logic                    mirror;
    logic                    tiled_x;
    logic                    tiled_y;
    logic                    feather;
  } cfg_t;

  typedef struct packed {
    logic [DIV_W-1:0] mag;
    logic             neg;
    logic [REM_W-1:0] rem;
    logic             q0;
  } lane_t;

  typedef struct packed {
    logic               on_canvas;
    logic [ALPHA_W-1:0] alpha;
    logic               inx;
    logic               iny;
    logic               x_lt;
    logic               x_ge;
    logic               y_lt;
    logic               y_ge;
    logic               meet;
    logic [PIX_W-1:0]   sx_lin;
    logic [PIX_W-1:0]   sy_lin;
  } ctx_t;

  typedef struct packed {
    lane_t [LANES-1:0] lanes;
    ctx_t              ctx;
  } div_t;

endpackage

### design/tile_layer_pixel_address.sv
// Top level of the tile layer pixel address unit.
//
// For each canvas pixel (pixel_x, pixel_y) transferred on the input channel, the block
// returns one result on the output channel: whether a pixel of the placed image lands
// there, which image column and row it is, and the feather alpha of the canvas border.
// Both channels transfer when valid is high and stall is low; a stalled result holds.
//
// Throughput is one pixel per clock while the receiver does not stall. Between an
// input transfer and the result being offered lie two front stages, one stage per
// quotient bit of the 14 bit tile index divider (four lanes in parallel), and the
// output register.
//
// When the receiver stalls, every stage holding an item freezes while empty stages
// ahead of it keep filling, so bubbles are squeezed out and the input is stalled only
// once the whole pipeline is full. Nothing is dropped or repeated.
//
// Reset clears all valid bits and loads the register reset values: sizes of one, zero
// offsets, centre anchor, single placement. The user must make configuration writes
// only while the block holds no items; the block itself does not enforce this.
module tile_layer_pixel_address import tlpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data
);

  cfg_t cfg;
  logic front_ready, div_valid, div_ready, back_valid, back_ready;
  div_t front_data, div_data;

  tlpa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tlpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .up_ready (front_ready),
    .in_data  (in_data),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_data  (front_data)
  );

  tlpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (div_valid),
    .up_ready (div_ready),
    .up_data  (front_data),
    .dn_valid (back_valid),
    .dn_ready (back_ready),
    .dn_data  (div_data)
  );

  tlpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .up_valid  (back_valid),
    .up_ready  (back_ready),
    .up_data   (div_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = !front_ready;

endmodule

### design/tlpa_cfg.sv
// Configuration registers and the derived sizes, anchor position and mode decode.
module tlpa_cfg import tlpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  logic [SIZE_W-1:0]       canvas_width, canvas_height, tile_width, tile_height;
  logic signed [OFS_W-1:0] offset_x, offset_y;
  logic [2:0]              anchor_mode;
  logic [4:0]              layout_mode;

  logic [SIZE_W-1:0]       cw1, ch1, tw1, th1;
  logic signed [OFS_W-1:0] ox1, oy1;
  logic [2:0]              anc1;
  logic                    clamp1, tiled1, mirror1, tx1, ty1, feather1;

  logic signed [POS_W-1:0] dw, dh, rw, rh, hw, hh, ax_next, ay_next;

  function automatic logic [SIZE_W-1:0] size_of(logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_SIZE)) begin
      r = SIZE_W'(MAX_SIZE);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= SIZE_W'(1);
      canvas_height <= SIZE_W'(1);
      tile_width    <= SIZE_W'(1);
      tile_height   <= SIZE_W'(1);
      offset_x      <= '0;
      offset_y      <= '0;
      anchor_mode   <= '0;
      layout_mode   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data[SIZE_W-1:0];
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data[SIZE_W-1:0];
        REG_TILE_WIDTH:    tile_width    <= cfg_data[SIZE_W-1:0];
        REG_TILE_HEIGHT:   tile_height   <= cfg_data[SIZE_W-1:0];
        REG_OFFSET_X:      offset_x      <= cfg_data[OFS_W-1:0];
        REG_OFFSET_Y:      offset_y      <= cfg_data[OFS_W-1:0];
        REG_ANCHOR_MODE:   anchor_mode   <= cfg_data[2:0];
        REG_LAYOUT_MODE:   layout_mode   <= cfg_data[4:0];
      endcase
    end
  end

  // First derived stage: clamped sizes and decoded layout.
  always_ff @(posedge clk) begin
    if (rst) begin
      cw1 <= SIZE_W'(1);
      ch1 <= SIZE_W'(1);
      tw1 <= SIZE_W'(1);
      th1 <= SIZE_W'(1);
      ox1 <= '0;
      oy1 <= '0;
      anc1 <= '0;
      clamp1 <= 1'b0;
      tiled1 <= 1'b0;
      mirror1 <= 1'b0;
      tx1 <= 1'b1;
      ty1 <= 1'b1;
      feather1 <= 1'b0;
    end else begin
      cw1 <= size_of(canvas_width);
      ch1 <= size_of(canvas_height);
      tw1 <= size_of(tile_width);
      th1 <= size_of(tile_height);
      ox1 <= offset_x;
      oy1 <= offset_y;
      anc1 <= anchor_mode;
      clamp1 <= (layout_mode[1:0] == LAYOUT_CLAMP);
      tiled1 <= (layout_mode[1:0] == LAYOUT_REPEAT) || (layout_mode[1:0] == LAYOUT_MIRROR);
      mirror1 <= (layout_mode[1:0] == LAYOUT_MIRROR);
      tx1 <= (layout_mode[3:2] != DIR_Y_ONLY);
      ty1 <= (layout_mode[3:2] != DIR_X_ONLY);
      feather1 <= layout_mode[4];
    end
  end

  // Centre anchoring halves the size difference, truncating toward zero.
  always_comb begin
    dw = $signed(POS_W'(cw1)) - $signed(POS_W'(tw1));
    dh = $signed(POS_W'(ch1)) - $signed(POS_W'(th1));
    rw = dw + $signed({{(POS_W-1){1'b0}}, dw[POS_W-1]});
    rh = dh + $signed({{(POS_W-1){1'b0}}, dh[POS_W-1]});
    hw = rw >>> 1;
    hh = rh >>> 1;
    unique case (anc1)
      ANCHOR_TOP_LEFT: begin
        ax_next = '0;
        ay_next = '0;
      end
      ANCHOR_TOP_RIGHT: begin
        ax_next = dw;
        ay_next = '0;
      end
      ANCHOR_BOTTOM_LEFT: begin
        ax_next = '0;
        ay_next = dh;
      end
      ANCHOR_BOTTOM_RIGHT: begin
        ax_next = dw;
        ay_next = dh;
      end
      default: begin
        ax_next = hw;
        ay_next = hh;
      end
    endcase
    ax_next = ax_next + POS_W'(ox1);
    ay_next = ay_next + POS_W'(oy1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{cw: SIZE_W'(1), ch: SIZE_W'(1), tw: SIZE_W'(1), th: SIZE_W'(1),
               ax: '0, ay: '0, clamp: 1'b0, tiled: 1'b0, mirror: 1'b0,
               tiled_x: 1'b1, tiled_y: 1'b1, feather: 1'b0};
    end else begin
      cfg.cw <= cw1;
      cfg.ch <= ch1;
      cfg.tw <= tw1;
      cfg.th <= th1;
      cfg.ax <= ax_next;
      cfg.ay <= ay_next;
      cfg.clamp <= clamp1;
      cfg.tiled <= tiled1;
      cfg.mirror <= mirror1;
      cfg.tiled_x <= tx1;
      cfg.tiled_y <= ty1;
      cfg.feather <= feather1;
    end
  end

endmodule

### design/tlpa_front.sv
// Front stages: positions relative to the anchor, placement flags, feather alpha, divider setup.
module tlpa_front import tlpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  output logic up_ready,
  input  in_t  in_data,
  output logic dn_valid,
  input  logic dn_ready,
  output div_t dn_data
);

  logic signed [POS_W-1:0] px, py, twx, thx, cwx, chx;
  logic signed [POS_W-1:0] n1x_c, n1y_c;
  logic [SIZE_W-1:0]       ex, ey, dxy, dxe, d_c;

  logic                    v1, v2, ld1, ld2;
  logic signed [POS_W-1:0] n1x, n1y, n2x, n2y;
  logic [SIZE_W-1:0]       d1;
  logic                    on_canvas1, inx1, iny1, xlt1, xge1, ylt1, yge1, meet1;

  logic [SIZE_W+ALPHA_W-1:0] prod;
  logic [ALPHA_W-1:0]        alpha_c;
  div_t                      nx2;

  assign ld2      = !v2 || dn_ready;
  assign ld1      = !v1 || ld2;
  assign up_ready = ld1;
  assign dn_valid = v2;

  always_comb begin
    px    = $signed(POS_W'(in_data.pixel_x));
    py    = $signed(POS_W'(in_data.pixel_y));
    twx   = $signed(POS_W'(cfg.tw));
    thx   = $signed(POS_W'(cfg.th));
    cwx   = $signed(POS_W'(cfg.cw));
    chx   = $signed(POS_W'(cfg.ch));
    n1x_c = px - cfg.ax;
    n1y_c = py - cfg.ay;
    // Distances to the far edges wrap outside the canvas; alpha is forced to zero there.
    ex    = cfg.cw - SIZE_W'(1) - SIZE_W'(in_data.pixel_x);
    ey    = cfg.ch - SIZE_W'(1) - SIZE_W'(in_data.pixel_y);
    dxy   = (in_data.pixel_x < in_data.pixel_y) ? SIZE_W'(in_data.pixel_x)
                                                : SIZE_W'(in_data.pixel_y);
    dxe   = (ex < ey) ? ex : ey;
    d_c   = (dxy < dxe) ? dxy : dxe;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ld1) begin
        v1 <= in_valid;
      end
      if (ld2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      n1x        <= n1x_c;
      n1y        <= n1y_c;
      n2x        <= -cfg.ax;
      n2y        <= -cfg.ay;
      d1         <= d_c;
      on_canvas1 <= (SIZE_W'(in_data.pixel_x) < cfg.cw) &&
                    (SIZE_W'(in_data.pixel_y) < cfg.ch);
      inx1       <= (n1x_c >= 0) && (n1x_c < twx);
      iny1       <= (n1y_c >= 0) && (n1y_c < thx);
      xlt1       <= (n1x_c < 0);
      xge1       <= (n1x_c >= twx);
      ylt1       <= (n1y_c < 0);
      yge1       <= (n1y_c >= thx);
      meet1      <= (cfg.ax < cwx) && (cfg.ax + twx > 0) && (cfg.ay < chx) && (cfg.ay + thx > 0);
    end
  end

  function automatic lane_t lane_init(logic signed [POS_W-1:0] n);
    lane_t l;
    logic signed [POS_W-1:0] m;
    m     = (n < 0) ? -n : n;
    l.mag = m[DIV_W-1:0];
    l.neg = (n < 0);
    l.rem = '0;
    l.q0  = 1'b0;
    return l;
  endfunction

  always_comb begin
    prod = (SIZE_W+ALPHA_W)'(d1) * (SIZE_W+ALPHA_W)'(ALPHA_FULL);
    if (!on_canvas1) begin
      alpha_c = '0;
    end else if (!cfg.feather || d1 >= SIZE_W'(FEATHER_WIDTH)) begin
      alpha_c = ALPHA_W'(ALPHA_FULL);
    end else begin
      alpha_c = ALPHA_W'(prod / FEATHER_WIDTH);
    end
    nx2.lanes[LANE_X_POS] = lane_init(n1x);
    nx2.lanes[LANE_X_ANC] = lane_init(n2x);
    nx2.lanes[LANE_Y_POS] = lane_init(n1y);
    nx2.lanes[LANE_Y_ANC] = lane_init(n2y);
    nx2.ctx.on_canvas = on_canvas1;
    nx2.ctx.alpha  = alpha_c;
    nx2.ctx.inx    = inx1;
    nx2.ctx.iny    = iny1;
    nx2.ctx.x_lt   = xlt1;
    nx2.ctx.x_ge   = xge1;
    nx2.ctx.y_lt   = ylt1;
    nx2.ctx.y_ge   = yge1;
    nx2.ctx.meet   = meet1;
    nx2.ctx.sx_lin = n1x[PIX_W-1:0];
    nx2.ctx.sy_lin = n1y[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      dn_data <= nx2;
    end
  end

endmodule

### design/tlpa_div.sv
// Pipelined restoring divider: one quotient bit per stage on four lanes at once.
module tlpa_div import tlpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic up_valid,
  output logic up_ready,
  input  div_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output div_t dn_data
);

  div_t             st  [DIV_W];
  div_t             src [DIV_W];
  div_t             nx  [DIV_W];
  logic [DIV_W-1:0] v, ld, pv;

  always_comb begin
    ld[DIV_W-1] = !v[DIV_W-1] || dn_ready;
    for (int j = DIV_W - 2; j >= 0; j--) begin
      ld[j] = !v[j] || ld[j+1];
    end
  end

  assign up_ready = ld[0];
  assign dn_valid = v[DIV_W-1];
  assign dn_data  = st[DIV_W-1];
  assign pv       = {v[DIV_W-2:0], up_valid};

  always_comb begin
    logic [REM_W:0]    trial;
    logic [SIZE_W-1:0] dv;
    src[0] = up_data;
    for (int j = 1; j < DIV_W; j++) begin
      src[j] = st[j-1];
    end
    for (int j = 0; j < DIV_W; j++) begin
      nx[j] = src[j];
      for (int l = 0; l < LANES; l++) begin
        dv    = (l >= LANE_Y_POS) ? cfg.th : cfg.tw;
        trial = {src[j].lanes[l].rem, src[j].lanes[l].mag[DIV_W-1-j]};
        if (trial >= {1'b0, dv}) begin
          nx[j].lanes[l].rem = REM_W'(trial - {1'b0, dv});
          nx[j].lanes[l].q0  = 1'b1;
        end else begin
          nx[j].lanes[l].rem = trial[REM_W-1:0];
          nx[j].lanes[l].q0  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int j = 0; j < DIV_W; j++) begin
        if (ld[j]) begin
          v[j] <= pv[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < DIV_W; j++) begin
      if (ld[j]) begin
        st[j] <= nx[j];
      end
    end
  end

endmodule

### design/tlpa_back.sv
// Result stage: floor correction, mirroring, layout selection and the output register.
module tlpa_back import tlpa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic up_valid,
  output logic up_ready,
  input  div_t up_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic              ld;
  logic [SIZE_W:0]   rx, ry;
  out_t              res;
  ctx_t              c;

  // Returns {hit, source coordinate} for one axis.
  function automatic logic [SIZE_W:0] axis_src(lane_t pos, lane_t anc, logic tiled,
                                               logic mirror, logic inr,
                                               logic [PIX_W-1:0] lin,
                                               logic [SIZE_W-1:0] size);
    logic              wrap1, wrap2, par1, par2, k;
    logic [SIZE_W-1:0] r, s;
    wrap1 = pos.neg && (pos.rem != '0);
    wrap2 = anc.neg && (anc.rem != '0);
    r     = wrap1 ? size - pos.rem : pos.rem;
    par1  = wrap1 ? !pos.q0 : pos.q0;
    par2  = wrap2 ? !anc.q0 : anc.q0;
    if (tiled) begin
      k = par1 ^ par2;
      s = r;
    end else begin
      k = par2;
      s = SIZE_W'(lin);
    end
    if (mirror && k) begin
      s = size - SIZE_W'(1) - s;
    end
    return {tiled || inr, s};
  endfunction

  assign ld       = !out_valid || !out_stall;
  assign up_ready = ld;
  assign c        = up_data.ctx;

  always_comb begin
    rx  = axis_src(up_data.lanes[LANE_X_POS], up_data.lanes[LANE_X_ANC], cfg.tiled_x,
                   cfg.mirror, c.inx, c.sx_lin, cfg.tw);
    ry  = axis_src(up_data.lanes[LANE_Y_POS], up_data.lanes[LANE_Y_ANC], cfg.tiled_y,
                   cfg.mirror, c.iny, c.sy_lin, cfg.th);
    res = '0;
    res.edge_alpha = c.alpha;
    if (c.on_canvas) begin
      if (!cfg.tiled) begin
        if (c.inx && c.iny) begin
          res.covered  = 1'b1;
          res.source_x = c.sx_lin;
          res.source_y = c.sy_lin;
        end else if (cfg.clamp && c.meet) begin
          priority if (c.iny && c.x_lt) begin
            res.covered  = 1'b1;
            res.source_y = c.sy_lin;
          end else if (c.iny && c.x_ge) begin
            res.covered  = 1'b1;
            res.source_x = PIX_W'(cfg.tw - SIZE_W'(1));
            res.source_y = c.sy_lin;
          end else if (c.inx && c.y_lt) begin
            res.covered  = 1'b1;
            res.source_x = c.sx_lin;
          end else if (c.inx && c.y_ge) begin
            res.covered  = 1'b1;
            res.source_x = c.sx_lin;
            res.source_y = PIX_W'(cfg.th - SIZE_W'(1));
          end else begin
            res.covered  = 1'b0;
          end
        end
      end else if (rx[SIZE_W] && ry[SIZE_W]) begin
        res.covered  = 1'b1;
        res.source_x = rx[PIX_W-1:0];
        res.source_y = ry[PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_data <= res;
    end
  end

endmodule
